// ----- rtl/rar_pkg.sv -----
`default_nettype none

package rar_pkg;

   // Widths of the result fields.
   localparam int RES_NUM_WIDTH = 33;
   localparam int RES_DEN_WIDTH = 32;

   // Operation codes carried in the kind field.
   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   // Which of the three cross products the shared multiplier forms.
   typedef enum logic [1:0] {
      MUL_FIRST  = 2'd0,
      MUL_SECOND = 2'd1,
      MUL_THIRD  = 2'd2
   } mul_step_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         mul_en;
      mul_step_type mul_step;
      logic         combine;
      logic         mags;
      logic         gcd_step;
      logic         div_load;
      logic         div_step;
      logic         out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_gcd;
      logic gcd_equal;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/rational_arithmetic_reduce.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   kind, a_num, a_den, b_num, b_den, reduce
// rsp       out        rsp_valid/rsp_stall   res_num, res_den, div_by_zero
//
// One beat is worked on at a time. Without reduction the beat passes capture, the
// three cross products, combine and the magnitude step; with reduction a binary
// GCD loop and the shift-subtract dividers follow before the result is loaded.
// The request side is stalled from
// acceptance until the result moves into the output register, which holds it
// while rsp_stall is high. Reset clears the controller and the result valid.

module rational_arithmetic_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_kind,
   input  wire logic signed [OPERAND_WIDTH-1:0]      req_a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0]      req_a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0]      req_b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0]      req_b_den,
   input  wire logic                                 req_reduce,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [rar_pkg::RES_NUM_WIDTH-1:0]  rsp_res_num,
   output logic signed [rar_pkg::RES_DEN_WIDTH-1:0]  rsp_res_den,
   output logic                                      rsp_div_by_zero
);
   import rar_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Multiplier, GCD and dividers.
   rar_dpath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_a_num       (req_a_num),
      .req_a_den       (req_a_den),
      .req_b_num       (req_b_num),
      .req_b_den       (req_b_den),
      .req_reduce      (req_reduce),
      .rsp_res_num     (rsp_res_num),
      .rsp_res_den     (rsp_res_den),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   // A division by zero always carries a zero fraction.
   a_dz_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_res_num == '0 && rsp_res_den == '0)
      else $error("division by zero with a nonzero result");

   // An accepted beat closes the request side on the next cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after a beat");

   // The controller issues at most one command per cycle.
   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mul_en, cmd.combine, cmd.mags, cmd.gcd_step,
                cmd.div_load, cmd.div_step, cmd.out_load}))
      else $error("overlapping datapath commands");

   // A pending result is never overwritten.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result loaded over a stalled beat");

endmodule

`default_nettype wire

// ----- rtl/rar_ctrl.sv -----
`default_nettype none

module rar_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rar_pkg::dp_cmd_type         cmd,
   input  wire rar_pkg::dp_status_type status
);
   import rar_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMBINE,
      ST_MAGS,
      ST_GCD,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Only an idle controller takes a new beat.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state, commands and result valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL0;
            end
         end
         ST_MUL0: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_FIRST;
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_SECOND;
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = MUL_THIRD;
            state_in     = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_MAGS;
         end
         ST_MAGS: begin
            cmd.mags = 1'b1;
            state_in = status.need_gcd ? ST_GCD : ST_FIN;
         end
         ST_GCD: begin
            if (status.gcd_equal) begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rar_dpath.sv -----
`default_nettype none

module rar_dpath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                                    clock,
   input  wire rar_pkg::dp_cmd_type                     cmd,
   output rar_pkg::dp_status_type                       status,
   input  wire logic [1:0]                              req_kind,
   input  wire logic signed [OPERAND_WIDTH-1:0]         req_a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0]         req_a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0]         req_b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0]         req_b_den,
   input  wire logic                                    req_reduce,
   output logic signed [rar_pkg::RES_NUM_WIDTH-1:0]     rsp_res_num,
   output logic signed [rar_pkg::RES_DEN_WIDTH-1:0]     rsp_res_den,
   output logic                                         rsp_div_by_zero
);
   import rar_pkg::*;

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int NW = PW + 1;
   localparam int CW = $clog2(PW);

   // Operand registers.
   kind_type               kind_ff, kind_in;
   logic signed [W-1:0]    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic                   reduce_ff, reduce_in;
   // Cross products and the raw result.
   logic signed [PW-1:0]   pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic signed [NW-1:0]   num_ff, num_in;
   logic signed [PW-1:0]   den_ff, den_in;
   logic                   dz_ff, dz_in;
   // Magnitudes, later the quotients.
   logic [PW-1:0]          mn_ff, mn_in, md_ff, md_in;
   // Binary GCD.
   logic [PW-1:0]          u_ff, u_in, v_ff, v_in;
   logic [CW-1:0]          k_ff, k_in;
   // Shift-subtract dividers, one per part.
   logic [PW-1:0]          g_ff, g_in;
   logic [PW-1:0]          nrem_ff, nrem_in, drem_ff, drem_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   // Result registers.
   logic signed [RES_NUM_WIDTH-1:0] res_num_ff, res_num_in;
   logic signed [RES_DEN_WIDTH-1:0] res_den_ff, res_den_in;
   logic                   res_dz_ff, res_dz_in;

   // Combinational helpers.
   logic signed [W-1:0]    mul_l, mul_r;
   logic signed [PW-1:0]   product;
   logic signed [NW-1:0]   num_comb;
   logic signed [PW-1:0]   den_comb;
   logic                   dz_comb;
   logic signed [NW-1:0]   num_abs;
   logic signed [PW-1:0]   den_abs;
   logic                   u_gt_v;
   logic [PW-1:0]          big, sml, diff;
   logic [PW:0]            nshift, ntrial, dshift, dtrial;
   logic signed [NW-1:0]   mag_signed, num_red;

   // Shared multiplier: picks the factors of the current cross product.
   always_comb begin
      mul_l = an_ff;
      mul_r = bd_ff;
      case (cmd.mul_step)
         MUL_FIRST: begin
            mul_l = an_ff;
            mul_r = (kind_ff == KIND_MUL) ? bn_ff : bd_ff;
         end
         MUL_SECOND: begin
            mul_l = (kind_ff == KIND_MUL) ? ad_ff : bn_ff;
            mul_r = (kind_ff == KIND_MUL) ? bd_ff : ad_ff;
         end
         MUL_THIRD: begin
            mul_l = ad_ff;
            mul_r = bd_ff;
         end
         default: begin
            mul_l = an_ff;
            mul_r = bd_ff;
         end
      endcase
      product = PW'(mul_l) * PW'(mul_r);
   end

   // Forms the raw numerator and denominator from the products.
   always_comb begin
      dz_comb  = (kind_ff == KIND_DIV) && (bn_ff == '0);
      num_comb = NW'(pa_ff);
      den_comb = pb_ff;
      case (kind_ff)
         KIND_ADD: begin
            num_comb = NW'(pa_ff) + NW'(pb_ff);
            den_comb = pc_ff;
         end
         KIND_SUB: begin
            num_comb = NW'(pa_ff) - NW'(pb_ff);
            den_comb = pc_ff;
         end
         default: begin
            // Multiply and divide use the first two products as they are.
            num_comb = NW'(pa_ff);
            den_comb = pb_ff;
         end
      endcase
      if (dz_comb) begin
         num_comb = '0;
         den_comb = '0;
      end
   end

   // Magnitudes of the raw parts.
   assign num_abs = num_ff[NW-1] ? -num_ff : num_ff;
   assign den_abs = den_ff[PW-1] ? -den_ff : den_ff;

   // One binary GCD step subtracts the smaller odd value from the larger.
   assign u_gt_v = (u_ff > v_ff);
   assign big    = u_gt_v ? u_ff : v_ff;
   assign sml    = u_gt_v ? v_ff : u_ff;
   assign diff   = big - sml;

   // Trial subtractions of both dividers.
   assign nshift = {nrem_ff, mn_ff[PW-1]};
   assign ntrial = nshift - {1'b0, g_ff};
   assign dshift = {drem_ff, md_ff[PW-1]};
   assign dtrial = dshift - {1'b0, g_ff};

   // Reduced numerator takes the sign of the unreduced quotient.
   assign mag_signed = $signed({1'b0, mn_ff});
   assign num_red    = (num_ff[NW-1] != den_ff[PW-1]) ? -mag_signed : mag_signed;

   // Status back to the controller.
   always_comb begin
      status.need_gcd  = reduce_ff && !dz_ff && (num_ff != '0) && (den_ff != '0);
      status.gcd_equal = (u_ff == v_ff);
      status.div_last  = (cnt_ff == CW'(PW - 1));
   end

   // Next values of all datapath registers.
   always_comb begin
      kind_in    = kind_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      reduce_in  = reduce_ff;
      pa_in      = pa_ff;
      pb_in      = pb_ff;
      pc_in      = pc_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      dz_in      = dz_ff;
      mn_in      = mn_ff;
      md_in      = md_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      k_in       = k_ff;
      g_in       = g_ff;
      nrem_in    = nrem_ff;
      drem_in    = drem_ff;
      cnt_in     = cnt_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      res_dz_in  = res_dz_ff;

      // Take the beat's operands.
      if (cmd.capture) begin
         kind_in   = kind_type'(req_kind);
         an_in     = req_a_num;
         ad_in     = req_a_den;
         bn_in     = req_b_num;
         bd_in     = req_b_den;
         reduce_in = req_reduce;
      end

      // Store the product of this step.
      if (cmd.mul_en) begin
         case (cmd.mul_step)
            MUL_FIRST:  pa_in = product;
            MUL_SECOND: pb_in = product;
            MUL_THIRD:  pc_in = product;
            default:    pc_in = product;
         endcase
      end

      if (cmd.combine) begin
         num_in = num_comb;
         den_in = den_comb;
         dz_in  = dz_comb;
      end

      // Magnitudes seed both the GCD and the dividers.
      if (cmd.mags) begin
         mn_in = num_abs[PW-1:0];
         md_in = den_abs[PW-1:0];
         u_in  = num_abs[PW-1:0];
         v_in  = den_abs[PW-1:0];
         k_in  = '0;
      end

      if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + CW'(1);
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_gt_v) begin
            u_in = diff >> 1;
         end else begin
            v_in = diff >> 1;
         end
      end

      // The divisor is the odd part restored by the common power of two.
      if (cmd.div_load) begin
         g_in    = u_ff << k_ff;
         nrem_in = '0;
         drem_in = '0;
         cnt_in  = '0;
      end

      // One quotient bit per part and cycle; quotients shift into mn and md.
      if (cmd.div_step) begin
         if (ntrial[PW]) begin
            nrem_in = nshift[PW-1:0];
            mn_in   = {mn_ff[PW-2:0], 1'b0};
         end else begin
            nrem_in = ntrial[PW-1:0];
            mn_in   = {mn_ff[PW-2:0], 1'b1};
         end
         if (dtrial[PW]) begin
            drem_in = dshift[PW-1:0];
            md_in   = {md_ff[PW-2:0], 1'b0};
         end else begin
            drem_in = dtrial[PW-1:0];
            md_in   = {md_ff[PW-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CW'(1);
      end

      // Result beat.
      if (cmd.out_load) begin
         res_dz_in = dz_ff;
         if (dz_ff) begin
            res_num_in = '0;
            res_den_in = '0;
         end else if (reduce_ff) begin
            res_num_in = RES_NUM_WIDTH'(num_red);
            res_den_in = RES_DEN_WIDTH'(md_ff);
         end else begin
            res_num_in = RES_NUM_WIDTH'(num_ff);
            res_den_in = RES_DEN_WIDTH'(den_ff);
         end
      end
   end

   // Datapath registers hold payload only.
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      reduce_ff  <= reduce_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      pc_ff      <= pc_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      dz_ff      <= dz_in;
      mn_ff      <= mn_in;
      md_ff      <= md_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      nrem_ff    <= nrem_in;
      drem_ff    <= drem_in;
      cnt_ff     <= cnt_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_dz_ff  <= res_dz_in;
   end

   assign rsp_res_num     = res_num_ff;
   assign rsp_res_den     = res_den_ff;
   assign rsp_div_by_zero = res_dz_ff;

endmodule

`default_nettype wire
